### src/sorted_priority_queue_unit_assert.svh
// assertion macros for the sorted priority queue unit
// depends on: clk and arst_n in the including module
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/spq_pkg.sv
// shared codes and types of the sorted priority queue unit
// depends on: nothing
`default_nettype none

package spq_pkg;

	localparam int FIELD_W  = 16;
	localparam int STATUS_W = 3;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_LIST   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic ins;
		logic shl;
	} cell_cmd_t;

endpackage

`default_nettype wire

### src/spq_cell.sv
// one storage cell of the sorted chain: holds a tag and key
// depends on: spq_pkg
`default_nettype none

module spq_cell #(
	parameter int TAG_BITS = 16,
	parameter int KEY_BITS = 16
) (
	input  wire                    clk,
	input  spq_pkg::cell_cmd_t     cmd,
	input  wire                    occupied,
	input  wire [TAG_BITS-1:0]     new_tag,
	input  wire [KEY_BITS-1:0]     new_key,
	input  wire                    left_gt,
	input  wire [TAG_BITS-1:0]     left_tag,
	input  wire [KEY_BITS-1:0]     left_key,
	input  wire [TAG_BITS-1:0]     right_tag,
	input  wire [KEY_BITS-1:0]     right_key,
	output logic [TAG_BITS-1:0]    tag,
	output logic [KEY_BITS-1:0]    key,
	output logic                   gt
);

	logic [TAG_BITS-1:0] tag_q;
	logic [KEY_BITS-1:0] key_q;

	assign tag = tag_q;
	assign key = key_q;
	assign gt  = occupied && (key_q > new_key);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_gt) begin
				tag_q <= left_tag;
				key_q <= left_key;
			end else if (!occupied || gt) begin
				tag_q <= new_tag;
				key_q <= new_key;
			end
		end else if (cmd.shl) begin
			tag_q <= right_tag;
			key_q <= right_key;
		end
	end

endmodule

`default_nettype wire

### src/sorted_priority_queue_unit.sv
// sorted priority queue: chain of compare cells with control and result register
// depends on: spq_pkg, spq_cell, sorted_priority_queue_unit_assert.svh
//
// channel   handshake             payload
// input     in_valid / in_ready   operation, tag, wait_key
// output    out_valid / out_ready status, out_tag, out_key, last
//
// insert and pop: every cell acts in parallel; insert compares and shifts, pop shifts
// list: one item per cycle while the output is not stalled, as the chain rotates
// reset clears the count, the result valid flag and the control state
// a stalled output holds the chain; no new input item while listing
`default_nettype none

module sorted_priority_queue_unit #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16,
	parameter int TAG_BITS = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire [1:0]                       operation,
	input  wire [spq_pkg::FIELD_W-1:0]      tag,
	input  wire [spq_pkg::FIELD_W-1:0]      wait_key,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [spq_pkg::STATUS_W-1:0]    status,
	output logic [spq_pkg::FIELD_W-1:0]     out_tag,
	output logic [spq_pkg::FIELD_W-1:0]     out_key,
	output logic                            last
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic STATE_IDLE = 1'b0;
	localparam logic STATE_LIST = 1'b1;

	logic                          state_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              list_idx_q;
	logic                          out_valid_q;
	logic [spq_pkg::STATUS_W-1:0]  status_q;
	logic [spq_pkg::FIELD_W-1:0]   out_tag_q;
	logic [spq_pkg::FIELD_W-1:0]   out_key_q;
	logic                          last_q;

	logic                          in_fire;
	logic                          out_free;
	logic                          list_emit;
	logic                          list_last;
	logic                          res_load;
	logic                          rot;
	spq_pkg::cell_cmd_t            cmd;
	logic [TAG_BITS-1:0]           new_tag;
	logic [KEY_BITS-1:0]           new_key;

	logic [TAG_BITS-1:0]           cell_tag [DEPTH];
	logic [KEY_BITS-1:0]           cell_key [DEPTH];
	logic                          cell_gt  [DEPTH];

	assign new_tag   = TAG_BITS'(tag);
	assign new_key   = KEY_BITS'(wait_key);
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == STATE_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign list_emit = (state_q == STATE_LIST) && out_free;
	assign list_last = (CNT_W'(list_idx_q + 1'b1) == count_q);
	assign rot       = list_emit;
	assign res_load  = list_emit || (in_fire && ((operation == spq_pkg::OP_INSERT)
		|| (operation == spq_pkg::OP_POP)
		|| ((operation == spq_pkg::OP_LIST) && (count_q == '0))));

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_tag   = out_tag_q;
	assign out_key   = out_key_q;
	assign last      = last_q;

	always_comb begin
		cmd.ins = 1'b0;
		cmd.shl = 1'b0;
		if (in_fire) begin
			case (operation)
				spq_pkg::OP_INSERT: cmd.ins = (count_q != CNT_W'(DEPTH));
				spq_pkg::OP_POP:    cmd.shl = (count_q != '0);
				default: ;
			endcase
		end
		if (rot) begin
			cmd.shl = 1'b1;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                occ;
			logic                lgt;
			logic [TAG_BITS-1:0] ltag;
			logic [KEY_BITS-1:0] lkey;
			logic [TAG_BITS-1:0] rtag;
			logic [KEY_BITS-1:0] rkey;

			assign occ = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign lgt  = 1'b0;
				assign ltag = new_tag;
				assign lkey = new_key;
			end else begin : g_body
				assign lgt  = cell_gt[gi-1];
				assign ltag = cell_tag[gi-1];
				assign lkey = cell_key[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign rtag = cell_tag[0];
				assign rkey = cell_key[0];
			end else begin : g_mid
				assign rtag = (rot && CNT_W'(gi + 1) == count_q) ? cell_tag[0] : cell_tag[gi+1];
				assign rkey = (rot && CNT_W'(gi + 1) == count_q) ? cell_key[0] : cell_key[gi+1];
			end

			spq_cell #(
				.TAG_BITS (TAG_BITS),
				.KEY_BITS (KEY_BITS)
			) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.occupied  (occ),
				.new_tag   (new_tag),
				.new_key   (new_key),
				.left_gt   (lgt),
				.left_tag  (ltag),
				.left_key  (lkey),
				.right_tag (rtag),
				.right_key (rkey),
				.tag       (cell_tag[gi]),
				.key       (cell_key[gi]),
				.gt        (cell_gt[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_IDLE;
			count_q     <= '0;
			list_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				case (operation)
					spq_pkg::OP_INSERT: begin
						if (count_q != CNT_W'(DEPTH)) begin
							count_q <= CNT_W'(count_q + 1'b1);
						end
					end
					spq_pkg::OP_POP: begin
						if (count_q != '0) begin
							count_q <= CNT_W'(count_q - 1'b1);
						end
					end
					spq_pkg::OP_LIST: begin
						if (count_q != '0) begin
							state_q    <= STATE_LIST;
							list_idx_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (list_emit) begin
				list_idx_q <= CNT_W'(list_idx_q + 1'b1);
				if (list_last) begin
					state_q <= STATE_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_q <= 1'b1;
			case (operation)
				spq_pkg::OP_INSERT: begin
					status_q  <= (count_q == CNT_W'(DEPTH)) ? spq_pkg::ST_FULL
						: spq_pkg::ST_INSERTED;
					out_tag_q <= '0;
					out_key_q <= '0;
				end
				spq_pkg::OP_POP: begin
					if (count_q == '0) begin
						status_q  <= spq_pkg::ST_EMPTY;
						out_tag_q <= '0;
						out_key_q <= '0;
					end else begin
						status_q  <= spq_pkg::ST_POPPED;
						out_tag_q <= spq_pkg::FIELD_W'(cell_tag[0]);
						out_key_q <= spq_pkg::FIELD_W'(cell_key[0]);
					end
				end
				default: begin
					status_q  <= spq_pkg::ST_EMPTY;
					out_tag_q <= '0;
					out_key_q <= '0;
				end
			endcase
		end else if (list_emit) begin
			status_q  <= spq_pkg::ST_LISTED;
			out_tag_q <= spq_pkg::FIELD_W'(cell_tag[0]);
			out_key_q <= spq_pkg::FIELD_W'(cell_key[0]);
			last_q    <= list_last;
		end
	end

`include "sorted_priority_queue_unit_assert.svh"

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "count above depth")
	`SPQ_ASSERT_NOW(a_no_accept_listing, state_q == STATE_LIST, !in_ready, "accept while listing")
	`SPQ_ASSERT_NEXT(a_pop_count, in_fire && operation == spq_pkg::OP_POP && count_q != '0, count_q == CNT_W'($past(count_q) - 1'b1), "pop did not shrink queue")
	`SPQ_ASSERT_NEXT(a_list_end, list_emit && list_last, state_q == STATE_IDLE && out_valid_q && last_q, "list did not end")

endmodule

`default_nettype wire
